// ----- hdl/median_window_filter_top_defines.svh -----
// Assertion macros shared by the filter's RTL files.
`ifndef MEDIAN_WINDOW_FILTER_TOP_DEFINES_SVH
`define MEDIAN_WINDOW_FILTER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MWF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MWF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mwf_pkg.sv -----
package mwf_pkg;

  // Largest window side and longest line held by the line memory.
  localparam int MAX_WINDOW = 5;
  localparam int MAX_LINE   = 1024;

  localparam int LINE_AW     = $clog2(MAX_LINE);
  localparam int WIN_N       = MAX_WINDOW * MAX_WINDOW;
  localparam int RANK_W      = $clog2(WIN_N + 1);
  localparam int WIN_IDX_W   = $clog2(MAX_WINDOW);
  localparam int LINE_WORD_W = 8 * (MAX_WINDOW - 1);
  // The pixel ring must reach back past the largest lag.
  localparam int RING_AW     = $clog2(MAX_WINDOW * MAX_LINE);
  localparam int RING_DEPTH  = 1 << RING_AW;

  localparam int PIX_W = 8;
  localparam int ROW_W = 12;
  localparam int COL_W = 10;

  // Item kinds on the input channel.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_WINDOW_HEIGHT = 3'd2,
    CFG_WINDOW_WIDTH  = 3'd3,
    CFG_ANCHOR_ROW    = 3'd4,
    CFG_ANCHOR_COL    = 3'd5
  } cfg_idx_t;

  typedef logic [WIN_N-1:0][PIX_W-1:0] pix_vec_t;

  // Per-result control and position data that rides with the window.
  typedef struct packed {
    logic [PIX_W-1:0] pass;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    logic             use_median;
  } out_info_t;

endpackage

// ----- hdl/mwf_median.sv -----
// Rank-based median select: compare matrix, rank count, then pick.
`include "median_window_filter_top_defines.svh"

module mwf_median (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_v,
  output logic                           in_rdy,
  input  mwf_pkg::pix_vec_t              in_vals,
  input  mwf_pkg::out_info_t             in_info,
  input  logic [mwf_pkg::RANK_W-1:0]     target,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mwf_pkg::PIX_W-1:0]      out_pixel_out,
  output logic [mwf_pkg::ROW_W-1:0]      out_row,
  output logic [mwf_pkg::COL_W-1:0]      out_col,
  output logic                           out_frame_last
);

  logic a_v_r, b_v_r, o_v_r;
  logic rdy_a, rdy_b, rdy_o;
  mwf_pkg::pix_vec_t  a_vals_r, b_vals_r;
  mwf_pkg::out_info_t a_info_r, b_info_r;
  logic [mwf_pkg::WIN_N-1:0][mwf_pkg::WIN_N-1:0] lt, a_lt_r;
  logic [mwf_pkg::WIN_N-1:0][mwf_pkg::RANK_W-1:0] b_rank_r;
  logic [mwf_pkg::WIN_N-1:0] match;
  logic [mwf_pkg::PIX_W-1:0] median;
  logic [mwf_pkg::PIX_W-1:0] o_pix_r;
  logic [mwf_pkg::ROW_W-1:0] o_row_r;
  logic [mwf_pkg::COL_W-1:0] o_col_r;
  logic                      o_last_r;

  // Stage ready chain from the output register back.
  assign rdy_o  = !o_v_r || !out_stall;
  assign rdy_b  = !b_v_r || rdy_o;
  assign rdy_a  = !a_v_r || rdy_b;
  assign in_rdy = rdy_a;

  // Element j ranks below element i; ties are broken by position.
  always_comb begin
    for (int i = 0; i < mwf_pkg::WIN_N; i++) begin
      for (int j = 0; j < mwf_pkg::WIN_N; j++) begin
        lt[i][j] = (in_vals[j] < in_vals[i]) || ((in_vals[j] == in_vals[i]) && (j < i));
      end
    end
  end

  // Exactly one element carries the target rank.
  always_comb begin
    median = '0;
    for (int i = 0; i < mwf_pkg::WIN_N; i++) begin
      match[i] = (b_rank_r[i] == target);
      if (match[i]) begin
        median = median | b_vals_r[i];
      end
    end
  end

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (rdy_a) a_v_r <= in_v;
      if (rdy_b) b_v_r <= a_v_r;
      if (rdy_o) o_v_r <= b_v_r;
    end
  end

  // Payload of the stages.
  always_ff @(posedge clk) begin
    if (rdy_a && in_v) begin
      a_vals_r <= in_vals;
      a_info_r <= in_info;
      a_lt_r   <= lt;
    end
    if (rdy_b && a_v_r) begin
      b_vals_r <= a_vals_r;
      b_info_r <= a_info_r;
      for (int i = 0; i < mwf_pkg::WIN_N; i++) begin
        b_rank_r[i] <= mwf_pkg::RANK_W'($countones(a_lt_r[i]));
      end
    end
    if (rdy_o && b_v_r) begin
      o_pix_r  <= b_info_r.use_median ? median : b_info_r.pass;
      o_row_r  <= b_info_r.row;
      o_col_r  <= b_info_r.col;
      o_last_r <= b_info_r.last;
    end
  end

  assign out_valid      = o_v_r;
  assign out_pixel_out  = o_pix_r;
  assign out_row        = o_row_r;
  assign out_col        = o_col_r;
  assign out_frame_last = o_last_r;

  `MWF_ASSERT_SAME(a_rank_unique, b_v_r && b_info_r.use_median, $onehot(match), "median rank not unique")

endmodule

// ----- hdl/median_window_filter_top.sv -----
// Channel  | Handshake            | Payload
// -------- | -------------------- | ------------------------------------------
// input    | in_valid / in_stall  | in_kind, in_pixel_in
// output   | out_valid / out_stall| out_pixel_out, out_row, out_col, out_frame_last
// config   | cfg_we               | cfg_index, cfg_data
//
// One item per cycle while in_stall is low; a result passes stage 1, stage 2, then the median's three registers.
// The pace is set by the column memory read-modify-write, with forwarding
// when consecutive pixels hit the same column.
// Reset is synchronous and clears control state; memories keep their contents.
// A stall on the output fills the pipeline stages before in_stall rises.
`include "median_window_filter_top_defines.svh"

module median_window_filter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [mwf_pkg::PIX_W-1:0]     in_pixel_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mwf_pkg::PIX_W-1:0]     out_pixel_out,
  output logic [mwf_pkg::ROW_W-1:0]     out_row,
  output logic [mwf_pkg::COL_W-1:0]     out_col,
  output logic                          out_frame_last,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [11:0]                   cfg_data
);

  localparam int MW = mwf_pkg::MAX_WINDOW;

  // Configuration registers.
  logic [10:0] img_w_r;
  logic [11:0] img_h_r;
  logic [2:0]  win_h_r, win_w_r, anc_row_r, anc_col_r;

  // Effective settings.
  logic [10:0] ew;
  logic [11:0] eh;
  logic [2:0]  wh, ww, ay, ax, dy, dx;
  logic [13:0] lag_full;
  logic [mwf_pkg::RING_AW-1:0] lag;
  logic [5:0]  n_full;
  logic [mwf_pkg::RANK_W-1:0] n_win, target;

  // Stream state.
  logic [mwf_pkg::RING_AW-1:0] pending_r, wp_r;
  logic [mwf_pkg::ROW_W-1:0]   emit_row_r;
  logic [mwf_pkg::COL_W-1:0]   emit_col_r;
  logic [mwf_pkg::LINE_AW-1:0] in_col_r;

  // Memories.
  logic [mwf_pkg::LINE_WORD_W-1:0] col_mem [mwf_pkg::MAX_LINE];
  logic [mwf_pkg::PIX_W-1:0]       ring_mem [mwf_pkg::RING_DEPTH];
  logic [mwf_pkg::LINE_WORD_W-1:0] col_rdata_r, fwd_word_r, old_word, col_wr_word;
  logic [mwf_pkg::PIX_W-1:0]       ring_rdata_r;

  // Stage 1: memory data returns.
  logic                            s1_v_r, s1_pix_r, s1_emit_r, s1_fwd_r;
  logic [mwf_pkg::PIX_W-1:0]       s1_pixel_r;
  logic [mwf_pkg::LINE_AW-1:0]     s1_wcol_r;
  mwf_pkg::out_info_t              s1_info_r;

  // Stage 2: window registers are current.
  logic                            s2_v_r, s2_pix_r;
  mwf_pkg::out_info_t              s2_info_r, s2_info;
  logic [MW-1:0][MW-1:0][mwf_pkg::PIX_W-1:0] win_r;
  logic [MW-1:0][mwf_pkg::PIX_W-1:0] new_vec;
  mwf_pkg::pix_vec_t               vals;

  logic in_acc, is_pix, emit_now, row_ok, col_ok, cfg_hit;
  logic med_rdy, rdy2, s1_go;

  // Saturate the configuration to usable values.
  always_comb begin
    if (img_w_r == 11'd0) ew = 11'd1;
    else if (img_w_r > 11'(mwf_pkg::MAX_LINE)) ew = 11'(mwf_pkg::MAX_LINE);
    else ew = img_w_r;
    eh = (img_h_r == 12'd0) ? 12'd1 : img_h_r;
    if (win_h_r == 3'd0) wh = 3'd1;
    else if (win_h_r > 3'(MW)) wh = 3'(MW);
    else wh = win_h_r;
    if (win_w_r == 3'd0) ww = 3'd1;
    else if (win_w_r > 3'(MW)) ww = 3'(MW);
    else ww = win_w_r;
    ay = (anc_row_r > wh - 3'd1) ? wh - 3'd1 : anc_row_r;
    ax = (anc_col_r > ww - 3'd1) ? ww - 3'd1 : anc_col_r;
    dy = wh - 3'd1 - ay;
    dx = ww - 3'd1 - ax;
    lag_full = 14'(dy) * 14'(ew) + 14'(dx);
    lag = lag_full[mwf_pkg::RING_AW-1:0];
    n_full = 6'(wh) * 6'(ww);
    n_win = n_full[mwf_pkg::RANK_W-1:0];
    target = mwf_pkg::RANK_W'(mwf_pkg::WIN_N) - n_win + (n_win >> 1);
  end

  // Item decode and emit decision.
  always_comb begin
    in_acc = in_valid && !in_stall;
    is_pix = (in_kind == mwf_pkg::KIND_PIXEL);
    emit_now = is_pix ? (pending_r >= lag) : (pending_r != '0);
    row_ok = (emit_row_r >= 12'(ay)) &&
             (13'(emit_row_r) - 13'(ay) + 13'(wh) <= 13'(eh));
    col_ok = (emit_col_r >= 10'(ax)) &&
             (12'(emit_col_r) - 12'(ax) + 12'(ww) <= 12'(ew));
    cfg_hit = cfg_we && (cfg_index <= 3'(mwf_pkg::CFG_ANCHOR_COL));
  end

  // Pipeline flow control.
  assign rdy2     = !s2_v_r || med_rdy;
  assign s1_go    = s1_v_r && rdy2;
  assign in_stall = s1_v_r && !rdy2;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r   <= 11'd640;
      img_h_r   <= 12'd480;
      win_h_r   <= 3'd3;
      win_w_r   <= 3'd3;
      anc_row_r <= 3'd1;
      anc_col_r <= 3'd1;
    end else if (cfg_we) begin
      unique case (mwf_pkg::cfg_idx_t'(cfg_index))
        mwf_pkg::CFG_IMAGE_WIDTH:   img_w_r   <= cfg_data[10:0];
        mwf_pkg::CFG_IMAGE_HEIGHT:  img_h_r   <= cfg_data;
        mwf_pkg::CFG_WINDOW_HEIGHT: win_h_r   <= cfg_data[2:0];
        mwf_pkg::CFG_WINDOW_WIDTH:  win_w_r   <= cfg_data[2:0];
        mwf_pkg::CFG_ANCHOR_ROW:    anc_row_r <= cfg_data[2:0];
        mwf_pkg::CFG_ANCHOR_COL:    anc_col_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Pending count, positions and write pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= '0;
      emit_row_r <= '0;
      emit_col_r <= '0;
      in_col_r   <= '0;
      wp_r       <= '0;
    end else if (cfg_hit) begin
      pending_r  <= '0;
      emit_row_r <= '0;
      emit_col_r <= '0;
      in_col_r   <= '0;
    end else if (in_acc) begin
      if (is_pix) begin
        wp_r <= wp_r + 1'b1;
        in_col_r <= (11'(in_col_r) + 11'd1 >= ew) ? '0 : in_col_r + 1'b1;
        if (!emit_now) pending_r <= pending_r + 1'b1;
      end else if (emit_now) begin
        pending_r <= pending_r - 1'b1;
      end
      if (emit_now) begin
        if (11'(emit_col_r) + 11'd1 >= ew) begin
          emit_col_r <= '0;
          emit_row_r <= (13'(emit_row_r) + 13'd1 >= 13'(eh)) ? '0 : emit_row_r + 1'b1;
        end else begin
          emit_col_r <= emit_col_r + 1'b1;
        end
      end
    end
  end

  // Column vector of the pixel in stage 1, with forwarding of the last write.
  always_comb begin
    old_word = s1_fwd_r ? fwd_word_r : col_rdata_r;
    new_vec[0] = s1_pixel_r;
    for (int b = 1; b < MW; b++) begin
      new_vec[b] = old_word[8*(b-1) +: 8];
    end
    col_wr_word = new_vec[MW-2:0];
  end

  // Column memory: read at transfer, write back when stage 1 moves on.
  always_ff @(posedge clk) begin
    if (in_acc && is_pix) begin
      col_rdata_r <= col_mem[in_col_r];
    end
    if (s1_go && s1_pix_r) begin
      col_mem[s1_wcol_r] <= col_wr_word;
      fwd_word_r <= col_wr_word;
    end
  end

  // Pixel ring: written by every pixel, read back for drained results.
  always_ff @(posedge clk) begin
    if (in_acc && is_pix) begin
      ring_mem[wp_r] <= in_pixel_in;
    end
    if (in_acc && !is_pix && emit_now) begin
      ring_rdata_r <= ring_mem[wp_r - pending_r];
    end
  end

  // Stage 1 registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc && (is_pix || emit_now)) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
    if (in_acc) begin
      s1_pix_r   <= is_pix;
      s1_emit_r  <= emit_now;
      s1_pixel_r <= in_pixel_in;
      s1_wcol_r  <= in_col_r;
      s1_fwd_r   <= s1_go && s1_pix_r && (s1_wcol_r == in_col_r);
      s1_info_r.pass <= '0;
      s1_info_r.row  <= emit_row_r;
      s1_info_r.col  <= emit_col_r;
      s1_info_r.last <= (emit_row_r == eh - 12'd1) && (11'(emit_col_r) == ew - 11'd1);
      s1_info_r.use_median <= is_pix && row_ok && col_ok;
    end
  end

  // Window registers shift one column per pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_go && s1_pix_r) begin
      win_r <= {win_r[MW-2:0], new_vec};
    end
  end

  // Stage 2 registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= s1_go && s1_emit_r;
    end
    if (s1_go && s1_emit_r) begin
      s2_pix_r  <= s1_pix_r;
      s2_info_r <= s1_info_r;
      s2_info_r.pass <= ring_rdata_r;
    end
  end

  // Mask the window to its configured size and pick the pass-through pixel.
  always_comb begin
    s2_info = s2_info_r;
    if (s2_pix_r) begin
      s2_info.pass = win_r[dx[mwf_pkg::WIN_IDX_W-1:0]][dy[mwf_pkg::WIN_IDX_W-1:0]];
    end
    for (int a = 0; a < MW; a++) begin
      for (int b = 0; b < MW; b++) begin
        vals[a*MW + b] = ((a < int'(ww)) && (b < int'(wh))) ? win_r[a][b] : '0;
      end
    end
  end

  mwf_median u_median (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_v           (s2_v_r),
    .in_rdy         (med_rdy),
    .in_vals        (vals),
    .in_info        (s2_info),
    .target         (target),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_out  (out_pixel_out),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_last (out_frame_last)
  );

  `MWF_ASSERT_SAME(a_stall_only_busy, in_stall, s1_v_r, "input stalled with stage 1 empty")
  `MWF_ASSERT_SAME(a_pending_bound, 1'b1, pending_r <= lag, "pending count above lag")
  `MWF_ASSERT_NEXT(a_idle_drain, in_acc && !is_pix && (pending_r == '0), !s1_v_r, "empty drain entered the pipeline")

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import mwf_pkg::*;

  localparam int RING_CELLS  = MAX_WINDOW * MAX_LINE;
  localparam int CYCLE_LIMIT = 800000;

  // One filtered pixel as the block reports it.
  typedef struct {
    logic [PIX_W-1:0] pix;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } filt_pixel_t;

  // Median filter predictor plus the queue of filtered pixels still owed.
  class median_scoreboard;
    byte unsigned ring[RING_CELLS];
    int           wr_ptr;
    int           pending;
    int           emit_row;
    int           emit_col;
    int           reg_width;
    int           reg_height;
    int           reg_win_h;
    int           reg_win_w;
    int           reg_anchor_r;
    int           reg_anchor_c;
    filt_pixel_t  owed[$];
    int           mismatches;

    function void reset_state();
      foreach (ring[i]) ring[i] = 0;
      wr_ptr = 0;
      pending = 0;
      emit_row = 0;
      emit_col = 0;
      reg_width = 640;
      reg_height = 480;
      reg_win_h = 3;
      reg_win_w = 3;
      reg_anchor_r = 1;
      reg_anchor_c = 1;
      owed.delete();
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [11:0] v);
      case (idx)
        CFG_IMAGE_WIDTH:   reg_width = v[10:0];
        CFG_IMAGE_HEIGHT:  reg_height = v;
        CFG_WINDOW_HEIGHT: reg_win_h = v[2:0];
        CFG_WINDOW_WIDTH:  reg_win_w = v[2:0];
        CFG_ANCHOR_ROW:    reg_anchor_r = v[2:0];
        CFG_ANCHOR_COL:    reg_anchor_c = v[2:0];
        default: return;
      endcase
      pending = 0;
      emit_row = 0;
      emit_col = 0;
    endfunction

    function int clip(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // Pixel that lies 'back' positions behind the write pointer.
    function byte unsigned ring_at(int back);
      return ring[(wr_ptr + RING_CELLS - (back % RING_CELLS)) % RING_CELLS];
    endfunction

    // Note one accepted transfer on the input channel.
    function void note_input(logic kind, logic [PIX_W-1:0] px);
      int ew, eh, wh, ww, ay, ax, lag, r, c, n, rel, j;
      byte unsigned win[MAX_WINDOW*MAX_WINDOW];
      byte unsigned v;
      bit in_frame;
      filt_pixel_t res;
      ew = clip(reg_width, 1, MAX_LINE);
      eh = clip(reg_height, 1, 4095);
      wh = clip(reg_win_h, 1, MAX_WINDOW);
      ww = clip(reg_win_w, 1, MAX_WINDOW);
      ay = (reg_anchor_r > wh - 1) ? wh - 1 : reg_anchor_r;
      ax = (reg_anchor_c > ww - 1) ? ww - 1 : reg_anchor_c;
      lag = (wh - 1 - ay) * ew + (ww - 1 - ax);
      r = emit_row;
      c = emit_col;
      if (kind == KIND_PIXEL) begin
        ring[wr_ptr] = px;
        wr_ptr = (wr_ptr + 1) % RING_CELLS;
        if (pending < RING_CELLS) pending++;
        if (pending <= lag) return;
      end else if (pending == 0) begin
        return;
      end
      in_frame = r >= ay && r - ay + wh <= eh && c >= ax && c - ax + ww <= ew;
      if (in_frame && pending > lag) begin
        n = 0;
        for (int k = 0; k < wh; k++) begin
          for (int l = 0; l < ww; l++) begin
            rel = (k - ay) * ew + (l - ax);
            win[n] = ring_at(pending - rel);
            n++;
          end
        end
        // Insertion sort, then pick the upper median.
        for (int i = 1; i < n; i++) begin
          v = win[i];
          j = i;
          while (j > 0 && win[j-1] > v) begin
            win[j] = win[j-1];
            j--;
          end
          win[j] = v;
        end
        res.pix = win[n/2];
      end else begin
        res.pix = ring_at(pending);
      end
      pending--;
      res.row = r[ROW_W-1:0];
      res.col = c[COL_W-1:0];
      res.last = (r == eh - 1 && c == ew - 1);
      owed.push_back(res);
      if (c + 1 >= ew) begin
        emit_col = 0;
        emit_row = (r + 1 >= eh) ? 0 : r + 1;
      end else begin
        emit_col = c + 1;
      end
    endfunction

    // Compare one accepted output transfer with the oldest owed pixel.
    function void check_result(filt_pixel_t got);
      filt_pixel_t exp_px;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected output pix=%0d row=%0d col=%0d last=%0b",
                   got.pix, got.row, got.col, got.last);
        return;
      end
      exp_px = owed.pop_front();
      if (got.pix !== exp_px.pix || got.row !== exp_px.row ||
          got.col !== exp_px.col || got.last !== exp_px.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected pix=%0d row=%0d col=%0d last=%0b, got pix=%0d row=%0d col=%0d last=%0b",
                   exp_px.pix, exp_px.row, exp_px.col, exp_px.last,
                   got.pix, got.row, got.col, got.last);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_kind;
  logic [PIX_W-1:0]    in_pixel_in;
  logic                out_valid;
  logic                out_stall;
  logic [PIX_W-1:0]    out_pixel_out;
  logic [ROW_W-1:0]    out_row;
  logic [COL_W-1:0]    out_col;
  logic                out_frame_last;
  logic                cfg_we;
  logic [2:0]          cfg_index;
  logic [11:0]         cfg_data;

  median_scoreboard sb;
  bit  quiet;
  bit  hold_request;
  int  cycles;

  median_window_filter_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_pixel_in    (in_pixel_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_out  (out_pixel_out),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_last (out_frame_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Check each output transfer.
  always @(posedge clk) begin
    filt_pixel_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.pix = out_pixel_out;
      got.row = out_row;
      got.col = out_col;
      got.last = out_frame_last;
      sb.check_result(got);
    end
  end

  // Output back-pressure: short and long stalls, plus one long hold-off on request.
  initial begin : receiver
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        n = 0;
        while (n < 300) begin
          @(negedge clk);
          n++;
        end
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one item and wait for its transfer; called and returns at a falling edge.
  task automatic send_item(logic kind, logic [PIX_W-1:0] px);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 2);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_pixel_in <= px;
    do @(posedge clk); while (in_stall);
    sb.note_input(kind, px);
    @(negedge clk);
  endtask

  // Wait until every owed pixel has left, then let the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.owed.size() > 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [11:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic set_geometry(int w, int h, int wh, int ww, int ay, int ax);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_WINDOW_HEIGHT, wh);
    write_reg(CFG_WINDOW_WIDTH, ww);
    write_reg(CFG_ANCHOR_ROW, ay);
    write_reg(CFG_ANCHOR_COL, ax);
    cfg_we <= 1'b0;
  endtask

  // Push out every pending pixel, plus one drain with nothing left.
  task automatic flush_frame();
    int n;
    n = sb.pending + 1;
    repeat (n) send_item(KIND_DRAIN, $urandom_range(0, 255));
  endtask

  function automatic int pick_width();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 2047;
      2: return $urandom_range(9, 40);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  function automatic int pick_height();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 4095;
      2: return $urandom_range(7, 20);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  initial begin : stimulus
    int sent, npix, phase;
    sb = new();
    sb.reset_state();
    quiet = 1'b0;
    hold_request = 1'b0;
    cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_PIXEL;
    in_pixel_in = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: drain with nothing pending, pixel extremes, a 4x3 frame, then flush.
    send_item(KIND_DRAIN, 8'hFF);
    set_geometry(4, 3, 3, 3, 1, 1);
    send_item(KIND_PIXEL, 8'h00);
    send_item(KIND_PIXEL, 8'hFF);
    send_item(KIND_PIXEL, 8'h80);
    send_item(KIND_PIXEL, 8'h7F);
    send_item(KIND_PIXEL, 8'h01);
    send_item(KIND_PIXEL, 8'hFE);
    send_item(KIND_PIXEL, 8'h55);
    send_item(KIND_PIXEL, 8'hAA);
    send_item(KIND_PIXEL, 8'h0F);
    send_item(KIND_PIXEL, 8'hF0);
    send_item(KIND_PIXEL, 8'hFF);
    send_item(KIND_PIXEL, 8'h00);
    flush_frame();
    // Window larger than the frame, anchors beyond the window, oversize registers.
    set_geometry(2047, 0, 7, 0, 7, 7);
    repeat (4) send_item(KIND_PIXEL, $urandom_range(0, 255));
    flush_frame();

    // Random frames with random geometry.
    sent = 0;
    phase = 0;
    while (sent < 850) begin
      set_geometry(pick_width(), pick_height(), $urandom_range(0, 7), $urandom_range(0, 7),
                   $urandom_range(0, 7), $urandom_range(0, 7));
      quiet = (phase % 5 == 3);
      if (phase == 4) hold_request = 1'b1;
      npix = $urandom_range(20, 70);
      for (int i = 0; i < npix; i++) begin
        if ($urandom_range(0, 29) == 0)
          send_item(KIND_DRAIN, $urandom_range(0, 255));
        else
          send_item(KIND_PIXEL, $urandom_range(0, 255));
        sent++;
      end
      flush_frame();
      quiet = 1'b0;
      phase++;
    end

    // One long line: widest frame, two-row window anchored at the top.
    set_geometry(1024, 4095, 2, 1, 0, 0);
    repeat (1100) send_item(KIND_PIXEL, $urandom_range(0, 255));
    flush_frame();

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
